### rtl/ssat_pkg.sv
package ssat_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int FS_W = 18;
	localparam int KNEE_W = 16;
	localparam int DIV_W = 64;
	localparam int Y_W = 17;
	localparam int SCALED_W = 19;

	localparam logic [FS_W-1:0] FS_RESET = 18'd43691;
	localparam logic [KNEE_W-1:0] KNEE_RESET = 16'd32768;
	localparam logic [Y_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic {
		REG_FULL_SCALE = 1'b0,
		REG_KNEE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic neg;
		logic use_term;
		logic [Y_W-1:0] base;
	} side_t;

endpackage

### rtl/ssat_div.sv
module ssat_div (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic [ssat_pkg::DIV_W-1:0] dividend,
	input logic [ssat_pkg::DIV_W-1:0] divisor,
	input ssat_pkg::side_t side,
	output logic q_valid,
	output logic [ssat_pkg::DIV_W-1:0] quotient,
	output ssat_pkg::side_t q_side
);
	import ssat_pkg::*;

	// One quotient bit per stage; the dividend register shifts the quotient in.
	logic [DIV_W-1:0] num_s [1:DIV_W];
	logic [DIV_W-1:0] rem_s [1:DIV_W];
	logic [DIV_W-1:0] den_s [1:DIV_W];
	side_t side_s [1:DIV_W];
	logic vld_s [1:DIV_W];

	for (genvar i = 0; i < DIV_W; i++) begin : g_stage
		logic [DIV_W-1:0] cur_num;
		logic [DIV_W-1:0] cur_rem;
		logic [DIV_W-1:0] cur_den;
		side_t cur_side;
		logic cur_vld;
		logic [DIV_W:0] trial;
		logic take;

		if (i == 0) begin : g_first
			assign cur_num = dividend;
			assign cur_rem = '0;
			assign cur_den = divisor;
			assign cur_side = side;
			assign cur_vld = valid;
		end else begin : g_rest
			assign cur_num = num_s[i];
			assign cur_rem = rem_s[i];
			assign cur_den = den_s[i];
			assign cur_side = side_s[i];
			assign cur_vld = vld_s[i];
		end

		assign trial = {cur_rem, cur_num[DIV_W-1]};
		assign take = trial >= {1'b0, cur_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			num_s[i+1] <= {cur_num[DIV_W-2:0], take};
			rem_s[i+1] <= take ? DIV_W'(trial - {1'b0, cur_den}) : trial[DIV_W-1:0];
			den_s[i+1] <= cur_den;
			side_s[i+1] <= cur_side;
		end
	end

	assign q_valid = vld_s[DIV_W];
	assign quotient = num_s[DIV_W];
	assign q_side = side_s[DIV_W];

endmodule

### rtl/soft_saturation_shaper_top.sv
// An item passes stage 1, both dividers, stages 2 to 5 and the output register to done.
// Throughput: one item per cycle; busy stays low and start may be high every cycle.
// The depth is set by two 64-stage restoring dividers, one quotient bit per stage.
// The receiver cannot stall, so the pipeline advances every cycle.
// Reset clears all valid bits and returns full_scale and knee to their reset values.
module soft_saturation_shaper_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [ssat_pkg::SAMPLE_WIDTH-1:0] sample_in,
	input logic cfg_we,
	input logic cfg_index,
	input logic [ssat_pkg::FS_W-1:0] cfg_wdata,
	output logic done,
	output logic signed [ssat_pkg::SAMPLE_WIDTH-1:0] sample_out
);
	import ssat_pkg::*;

	localparam int W = SAMPLE_WIDTH;
	localparam int CW = ((W > SCALED_W) ? W : SCALED_W) + 1;
	localparam logic [CW-1:0] LIM_POS = CW'((64'd1 << (W - 1)) - 64'd1);
	localparam logic [CW-1:0] LIM_NEG = CW'(64'd1 << (W - 1));

	logic [FS_W-1:0] full_scale_q;
	logic [KNEE_W-1:0] knee_q;
	logic [32:0] a2_q;
	logic [FS_W-1:0] fs_eff;
	logic [KNEE_W:0] a_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FS_RESET;
			knee_q <= KNEE_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FULL_SCALE: full_scale_q <= cfg_wdata;
				REG_KNEE: knee_q <= cfg_wdata[KNEE_W-1:0];
				default: ;
			endcase
		end
	end

	assign fs_eff = (full_scale_q == '0) ? FS_W'(1) : full_scale_q;
	assign a_val = ONE_Q16 - {1'b0, knee_q};

	// Write the knee only while idle (unchecked); a2 is registered from the knee.
	always_ff @(posedge clk) begin
		a2_q <= 33'(a_val) * 33'(a_val);
	end

	assign busy = 1'b0;

	// Stage 1: sign and magnitude. Negating the most negative value gives 2^(W-1).
	logic vld_s1;
	logic neg_s1;
	logic [W-1:0] mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= sample_in[W-1];
		mag_s1 <= sample_in[W-1] ? W'(-sample_in) : W'(sample_in);
	end

	side_t side1;
	logic x_vld;
	logic [DIV_W-1:0] x_quo;
	side_t x_side;

	assign side1 = '{neg: neg_s1, use_term: 1'b0, base: '0};

	ssat_div u_norm_div (
		.clk(clk),
		.arst_n(arst_n),
		.valid(vld_s1),
		.dividend(DIV_W'({mag_s1, 16'h0000})),
		.divisor(DIV_W'(fs_eff)),
		.side(side1),
		.q_valid(x_vld),
		.quotient(x_quo),
		.q_side(x_side)
	);

	// Stage 2: distance above the knee.
	logic [DIV_W-1:0] d_full;
	logic gt;
	logic big;
	logic vld_s2;
	side_t side_s2;
	logic [31:0] d_s2;

	assign gt = x_quo > DIV_W'(knee_q);
	assign d_full = x_quo - DIV_W'(knee_q);
	assign big = |d_full[DIV_W-1:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= x_vld;
		end
	end

	always_ff @(posedge clk) begin
		side_s2.neg <= x_side.neg;
		side_s2.use_term <= gt && !big;
		side_s2.base <= gt ? Y_W'(knee_q) : x_quo[Y_W-1:0];
		// Without a shaping term the divider still sees a nonzero divisor.
		d_s2 <= (gt && !big) ? d_full[31:0] : 32'h0;
	end

	// Stage 3: numerator and denominator, wrapped to 64 bits.
	logic [64:0] p_num;
	logic [63:0] p_dd;
	logic vld_s3;
	side_t side_s3;
	logic [DIV_W-1:0] num_s3;
	logic [DIV_W-1:0] den_s3;

	assign p_num = 65'(d_s2) * 65'(a2_q);
	assign p_dd = 64'(d_s2) * 64'(d_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		num_s3 <= p_num[63:0];
		den_s3 <= p_dd + 64'(a2_q);
	end

	logic t_vld;
	logic [DIV_W-1:0] t_quo;
	side_t t_side;

	ssat_div u_shape_div (
		.clk(clk),
		.arst_n(arst_n),
		.valid(vld_s3),
		.dividend(num_s3),
		.divisor(den_s3),
		.side(side_s3),
		.q_valid(t_vld),
		.quotient(t_quo),
		.q_side(t_side)
	);

	// Stage 4: shaped value, with the fallback above full scale.
	logic [DIV_W-1:0] y_sum;
	logic [Y_W-1:0] y_val;
	logic vld_s4;
	logic neg_s4;
	logic [Y_W-1:0] y_s4;

	assign y_sum = t_side.use_term ? DIV_W'(t_side.base) + t_quo : DIV_W'(t_side.base);
	assign y_val = (y_sum > DIV_W'(ONE_Q16)) ? Y_W'((Y_W'(knee_q) + ONE_Q16) >> 1)
		: y_sum[Y_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= t_vld;
		end
	end

	always_ff @(posedge clk) begin
		neg_s4 <= t_side.neg;
		y_s4 <= y_val;
	end

	// Stage 5: rescale with round half up.
	logic [34:0] prod;
	logic vld_s5;
	logic neg_s5;
	logic [SCALED_W-1:0] scaled_s5;

	assign prod = 35'(y_s4) * 35'(fs_eff) + 35'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		neg_s5 <= neg_s4;
		scaled_s5 <= prod[34:16];
	end

	// Output register: restore sign and saturate.
	logic [CW-1:0] sc;
	logic [CW-1:0] clamped;
	logic done_q;
	logic [W-1:0] sample_out_q;

	assign sc = CW'(scaled_s5);
	always_comb begin
		if (neg_s5) begin
			clamped = (sc > LIM_NEG) ? LIM_NEG : sc;
		end else begin
			clamped = (sc > LIM_POS) ? LIM_POS : sc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		sample_out_q <= neg_s5 ? W'(-clamped) : clamped[W-1:0];
	end

	assign done = done_q;
	assign sample_out = sample_out_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##134 done)
		else $error("accepted item did not produce a result on time");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 134))
		else $error("result without an accepted item");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(sample_in[W-1], 134)) |-> !sample_out[W-1])
		else $error("positive input gave negative output");

endmodule

### tb/tb_soft_saturation_shaper_top.sv
module tb_soft_saturation_shaper_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ssat_pkg::*;

	localparam int LATENCY = 133;
	localparam int W = SAMPLE_WIDTH;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [W-1:0] sample_in;
	logic cfg_we;
	logic cfg_index;
	logic [FS_W-1:0] cfg_wdata;
	logic done;
	logic signed [W-1:0] sample_out;

	soft_saturation_shaper_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_in(sample_in), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .done(done), .sample_out(sample_out)
	);

	logic [FS_W-1:0] full_scale_q;
	logic [KNEE_W-1:0] knee_q;

	logic [W-1:0] pending_samples[$];
	logic [W-1:0] expected_samples[$];
	int idle_pct;
	int errors;
	bit driving;

	function automatic logic [W-1:0] shape_sample(logic [W-1:0] raw);
		logic neg;
		logic [63:0] mag, fs, x, y, d, a, a2, term, scaled;
		logic [W-1:0] res;
		neg = raw[W-1];
		mag = neg ? 64'((~raw) + 1'b1) & ((64'd1 << W) - 1) : 64'(raw);
		if (neg && mag == 0)
			mag = 64'd1 << (W-1);
		fs = (full_scale_q == 0) ? 64'd1 : 64'(full_scale_q);
		x = (mag << 16) / fs;
		y = x;
		if (x > 64'(knee_q)) begin
			d = x - 64'(knee_q);
			a = 64'd65536 - 64'(knee_q);
			a2 = a * a;
			term = 0;
			if (d < (64'd1 << 32))
				term = (d * a2) / (a2 + d * d);
			y = 64'(knee_q) + term;
		end
		if (y > 64'd65536)
			y = (64'(knee_q) + 64'd65536) / 2;
		scaled = (y * fs + 64'd32768) >> 16;
		if (neg) begin
			if (scaled > (64'd1 << (W-1)))
				scaled = 64'd1 << (W-1);
			res = W'((~scaled) + 1);
		end else begin
			if (scaled > ((64'd1 << (W-1)) - 1))
				scaled = (64'd1 << (W-1)) - 1;
			res = W'(scaled);
		end
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("tb_soft_saturation_shaper_top NOT OK");
		$finish;
	end

	// The driver offers the head of the queue and pops it once the item is accepted.
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_samples.push_back(shape_sample(sample_in));
			void'(pending_samples.pop_front());
		end
		if (!(start && busy)) begin
			if (driving && pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
				sample_in <= pending_samples[0];
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (done) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected result %h", $time, sample_out);
				errors++;
			end else begin
				if (sample_out !== expected_samples[0]) begin
					$display("%0t: sample_out expected %h actual %h", $time,
						expected_samples[0], sample_out);
					errors++;
				end
				void'(expected_samples.pop_front());
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [FS_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FULL_SCALE)
			full_scale_q = value;
		else
			knee_q = value[KNEE_W-1:0];
	endtask

	task automatic run_items(int pct);
		idle_pct = pct;
		driving = 1'b1;
		while (pending_samples.size() != 0 || start)
			@(posedge clk);
		driving = 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [W-1:0] random_sample();
		case ($urandom_range(3))
			0: return W'($urandom);
			1: return W'($urandom_range(4095)) - W'(2048);
			2: return {$urandom_range(1) ? 4'hF : 4'h0, (W-4)'($urandom)};
			default: return $urandom_range(1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
		endcase
	endfunction

	initial begin
		logic [FS_W-1:0] fs_set[6];
		logic [KNEE_W-1:0] knee_set[6];
		int pcts[4];
		fs_set = '{18'd43691, 18'd327, 18'd131072, 18'd0, 18'h3FFFF, 18'd32768};
		knee_set = '{16'd32768, 16'd0, 16'd64880, 16'hFFFF, 16'd16384, 16'd50000};
		pcts = '{0, 86, 32, 0};
		errors = 0;
		driving = 1'b0;
		idle_pct = 0;
		start = 1'b0;
		sample_in = '0;
		cfg_we = 1'b0;
		cfg_index = REG_FULL_SCALE;
		cfg_wdata = '0;
		full_scale_q = FS_RESET;
		knee_q = KNEE_RESET;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed items under the reset configuration.
		pending_samples = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
			24'h800001, 24'h400000, 24'hC00000, 24'h005555, 24'hFFAAAB, 24'h2AAAAB,
			24'h555555, 24'h123456, 24'hEDCBA9};
		run_items(0);
		for (int s = 0; s < 6; s++) begin
			write_reg(REG_FULL_SCALE, fs_set[s]);
			write_reg(REG_KNEE, FS_W'(knee_set[(s + 1) % 6]));
			for (int p = 0; p < 4; p++) begin
				for (int i = 0; i < 48; i++)
					pending_samples.push_back(random_sample());
				run_items(pcts[p]);
			end
		end
		if (errors == 0)
			$display("tb_soft_saturation_shaper_top OK");
		else
			$display("tb_soft_saturation_shaper_top NOT OK");
		$finish;
	end
endmodule

### soft_saturation_shaper_top.f
rtl/ssat_pkg.sv
rtl/ssat_div.sv
rtl/soft_saturation_shaper_top.sv
tb/tb_soft_saturation_shaper_top.sv
